### rtl/core/finite_buffer_queue_timing_model_macros.svh
// ------------------------------------------------------------------------
// finite buffer queue timing model - assertion macros
// shared property shapes for the queue model checks
// ------------------------------------------------------------------------
`ifndef FINITE_BUFFER_QUEUE_TIMING_MODEL_MACROS_SVH
`define FINITE_BUFFER_QUEUE_TIMING_MODEL_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define FBQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define FBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/fbq_pkg.sv
// ------------------------------------------------------------------------
// fbq_pkg
// types and fixed constants of the finite buffer queue timing model
// ------------------------------------------------------------------------
package fbq_pkg;

	localparam int TIME_W     = 48;
	localparam int BITS_W     = 24;
	localparam int RATE_W     = 32;
	localparam int LIMIT_W    = 16;
	localparam int FIELD_W    = 32;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUF_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_RATE = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_OBSERVE = 2'd0,
		OP_ARRIVE  = 2'd1,
		OP_DEPART  = 2'd2,
		OP_NONE    = 2'd3
	} fbq_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIVIDE,
		ST_DONE
	} fbq_state_t;

	// status into the sequencer
	typedef struct packed {
		logic evt_valid;
		logic is_arrival;
		logic drop;
		logic div_done;
		logic res_free;
	} fbq_stat_t;

	// strobes out of the sequencer
	typedef struct packed {
		logic evt_ready;
		logic capture;
		logic decide;
		logic div_start;
		logic commit;
	} fbq_ctrl_t;

endpackage

### rtl/core/fbq_div.sv
// ------------------------------------------------------------------------
// fbq_div
// radix-2 restoring divider, floor(num * 2^FRAC_W / den), one bit a cycle
// ------------------------------------------------------------------------
module fbq_div #(
	parameter int NUM_W  = 24,
	parameter int FRAC_W = 32,
	parameter int DEN_W  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUM_W-1:0]          num,
	input  logic [DEN_W-1:0]          den,
	output logic                      busy,
	output logic                      done,
	output logic [NUM_W+FRAC_W-1:0]   quo
);

	localparam int QUO_W  = NUM_W + FRAC_W;
	localparam int STEP_W = $clog2(QUO_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;
	logic [DEN_W-1:0]  rem_nx;

	// dividend bits shift out of the top of quo_q as quotient bits shift in
	always_comb begin
		trial  = {rem_q, quo_q[QUO_W-1]};
		diff   = trial - {1'b0, den_q};
		fits   = (trial >= {1'b0, den_q});
		rem_nx = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= STEP_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - STEP_W'(1);
				done_q <= (cnt_q == STEP_W'(1));
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= {num, {FRAC_W{1'b0}}};
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/fbq_ctrl.sv
// ------------------------------------------------------------------------
// fbq_ctrl
// event sequencer: capture, admission decision, divide, commit
// ------------------------------------------------------------------------
module fbq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  fbq_pkg::fbq_stat_t stat,
	output fbq_pkg::fbq_ctrl_t ctrl
);

	import fbq_pkg::*;

	fbq_state_t state_q;
	fbq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.evt_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.is_arrival && !stat.drop) state_d = ST_DIVIDE;
				else state_d = ST_DONE;
			end
			ST_DIVIDE: begin
				if (stat.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.res_free) state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.evt_ready = 1'b1;
				ctrl.capture   = stat.evt_valid;
			end
			ST_DECIDE: begin
				ctrl.decide    = 1'b1;
				ctrl.div_start = stat.is_arrival && !stat.drop;
			end
			ST_DIVIDE: begin
				ctrl = '0;
			end
			ST_DONE: begin
				ctrl.commit = stat.res_free;
			end
		endcase
	end

endmodule

### rtl/core/finite_buffer_queue_timing_model.sv
// ------------------------------------------------------------------------
// finite_buffer_queue_timing_model
// sequence: an admitted arrival passes capture, decide, divide and commit to the
//   result; any other event goes from decide straight to commit
// a new request is taken only while the sequencer is idle, so an admitted arrival
//   holds off the next request until the delay divider is done and its result is committed
// reset: asynchronous, clears the model counters and times, registers to defaults
// ------------------------------------------------------------------------
`include "finite_buffer_queue_timing_model_macros.svh"

module finite_buffer_queue_timing_model #(
	parameter int COUNT_WIDTH        = 32,
	parameter int TIME_FRACTION_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [fbq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fbq_pkg::CFG_DATA_W-1:0]    cfg_data,
	// event requests
	input  logic                              evt_valid,
	output logic                              evt_ready,
	input  logic [fbq_pkg::OP_W-1:0]          opcode,
	input  logic [fbq_pkg::TIME_W-1:0]        event_time,
	input  logic [fbq_pkg::BITS_W-1:0]        packet_bits,
	// results
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic                              accepted,
	output logic                              dropped,
	output logic [fbq_pkg::TIME_W-1:0]        departure_time,
	output logic [fbq_pkg::FIELD_W-1:0]       occupancy,
	output logic [fbq_pkg::FIELD_W-1:0]       arrival_total,
	output logic [fbq_pkg::FIELD_W-1:0]       loss_total,
	output logic [fbq_pkg::FIELD_W-1:0]       departure_total,
	output logic [fbq_pkg::FIELD_W-1:0]       observation_total,
	output logic [fbq_pkg::FIELD_W-1:0]       idle_total,
	output logic [fbq_pkg::TIME_W-1:0]        occupancy_sum
);

	import fbq_pkg::*;

	localparam int CW    = COUNT_WIDTH;
	localparam int QUO_W = BITS_W + TIME_FRACTION_BITS;
	localparam logic [CW-1:0] CNT_MAX = '1;

	// saturating counter step
	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
		return (c == CNT_MAX) ? c : c + CW'(1);
	endfunction

	// counters wider than the report field show as its maximum
	function automatic logic [FIELD_W-1:0] clamp32(input logic [CW-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_W-1:0];
	endfunction

	// configuration registers
	logic                limit_en_q;
	logic [LIMIT_W-1:0]  buf_limit_q;
	logic [RATE_W-1:0]   link_rate_q;

	// model state
	logic [CW-1:0]       arrivals_q;
	logic [CW-1:0]       departures_q;
	logic [CW-1:0]       losses_q;
	logic [CW-1:0]       observations_q;
	logic [CW-1:0]       idle_obs_q;
	logic [TIME_W-1:0]   occ_acc_q;
	logic [TIME_W-1:0]   last_dep_q;
	logic                last_dep_valid_q;

	// captured request and working values
	fbq_op_t             opcode_q;
	logic [TIME_W-1:0]   time_q;
	logic [BITS_W-1:0]   bits_q;
	logic [CW-1:0]       occ_q;
	logic                drop_q;
	logic [TIME_W-1:0]   delay_q;

	// result register
	logic                res_valid_q;
	logic                accepted_q;
	logic                dropped_q;
	logic [TIME_W-1:0]   departure_time_q;
	logic [FIELD_W-1:0]  occupancy_q;
	logic [FIELD_W-1:0]  arrival_total_q;
	logic [FIELD_W-1:0]  loss_total_q;
	logic [FIELD_W-1:0]  departure_total_q;
	logic [FIELD_W-1:0]  observation_total_q;
	logic [FIELD_W-1:0]  idle_total_q;
	logic [TIME_W-1:0]   occupancy_sum_q;

	fbq_stat_t           stat;
	fbq_ctrl_t           ctrl;

	logic                div_busy;
	logic                div_done;
	logic [QUO_W-1:0]    div_quo;

	logic [CW:0]         gone;
	logic [CW:0]         occ_diff;
	logic [CW-1:0]       occ_now;
	logic                drop_now;
	logic [63:0]         quo_ext;
	logic [TIME_W-1:0]   delay_nx;
	logic [TIME_W-1:0]   start_time;
	logic [TIME_W:0]     dep_sum;
	logic [TIME_W-1:0]   dep_time;
	logic [TIME_W:0]     acc_sum;

	logic                is_obs;
	logic                is_arr;
	logic                is_dep;
	logic                admit;
	logic [CW-1:0]       arrivals_nx;
	logic [CW-1:0]       departures_nx;
	logic [CW-1:0]       losses_nx;
	logic [CW-1:0]       observations_nx;
	logic [CW-1:0]       idle_obs_nx;
	logic [TIME_W-1:0]   occ_acc_nx;

	// configuration port, writes beyond the register list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_en_q  <= 1'b1;
			buf_limit_q <= LIMIT_W'(16);
			link_rate_q <= RATE_W'(1000000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIMIT_EN:  limit_en_q  <= cfg_data[0];
				REG_BUF_LIMIT: buf_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_LINK_RATE: link_rate_q <= cfg_data[RATE_W-1:0];
				default:       limit_en_q  <= limit_en_q;
			endcase
		end
	end

	// occupancy from the counters, floored at zero when departures run ahead
	always_comb begin
		gone     = {1'b0, departures_q} + {1'b0, losses_q};
		occ_diff = {1'b0, arrivals_q} - gone;
		occ_now  = ({1'b0, arrivals_q} > gone) ? occ_diff[CW-1:0] : '0;
	end

	// tail drop when the limit is on and the buffer is at or past it
	assign drop_now = (opcode_q == OP_ARRIVE) && limit_en_q &&
	                  (64'(occ_q) >= 64'(buf_limit_q));

	// sequencer
	assign stat.evt_valid  = evt_valid;
	assign stat.is_arrival = (opcode_q == OP_ARRIVE);
	assign stat.drop       = drop_now;
	assign stat.div_done   = div_done;
	assign stat.res_free   = !res_valid_q || res_ready;

	fbq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// transmission delay divider, bits * 2^frac / rate
	fbq_div #(
		.NUM_W  (BITS_W),
		.FRAC_W (TIME_FRACTION_BITS),
		.DEN_W  (RATE_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.num    (bits_q),
		.den    (link_rate_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// zero rate and an oversized quotient both saturate the delay
	always_comb begin
		quo_ext  = 64'(div_quo);
		delay_nx = ((link_rate_q == '0) || (quo_ext > 64'(TIME_MAX))) ?
		           TIME_MAX : quo_ext[TIME_W-1:0];
	end

	// departure starts at the arrival when empty or nothing scheduled yet
	always_comb begin
		start_time = ((occ_q == '0) || !last_dep_valid_q) ? time_q : last_dep_q;
		dep_sum    = {1'b0, start_time} + {1'b0, delay_q};
		dep_time   = dep_sum[TIME_W] ? TIME_MAX : dep_sum[TIME_W-1:0];
	end

	// state update for the request being committed
	always_comb begin
		is_obs = (opcode_q == OP_OBSERVE);
		is_arr = (opcode_q == OP_ARRIVE);
		is_dep = (opcode_q == OP_DEPART);
		admit  = is_arr && !drop_q;

		arrivals_nx     = is_arr ? sat_inc(arrivals_q) : arrivals_q;
		losses_nx       = (is_arr && drop_q) ? sat_inc(losses_q) : losses_q;
		departures_nx   = is_dep ? sat_inc(departures_q) : departures_q;
		observations_nx = is_obs ? sat_inc(observations_q) : observations_q;
		idle_obs_nx     = (is_obs && (occ_q == '0)) ? sat_inc(idle_obs_q) : idle_obs_q;

		acc_sum    = {1'b0, occ_acc_q} + (TIME_W + 1)'(occ_q);
		occ_acc_nx = occ_acc_q;
		if (is_obs) begin
			occ_acc_nx = acc_sum[TIME_W] ? TIME_MAX : acc_sum[TIME_W-1:0];
		end
	end

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			opcode_q <= fbq_op_t'(opcode);
			time_q   <= event_time;
			bits_q   <= packet_bits;
			occ_q    <= occ_now;
		end
		if (ctrl.decide) begin
			drop_q <= drop_now;
		end
		if (div_done) begin
			delay_q <= delay_nx;
		end
	end

	// model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrivals_q       <= '0;
			departures_q     <= '0;
			losses_q         <= '0;
			observations_q   <= '0;
			idle_obs_q       <= '0;
			occ_acc_q        <= '0;
			last_dep_q       <= '0;
			last_dep_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			arrivals_q     <= arrivals_nx;
			departures_q   <= departures_nx;
			losses_q       <= losses_nx;
			observations_q <= observations_nx;
			idle_obs_q     <= idle_obs_nx;
			occ_acc_q      <= occ_acc_nx;
			if (admit) begin
				last_dep_q       <= dep_time;
				last_dep_valid_q <= 1'b1;
			end
		end
	end

	// result register, frees the sequencer while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			accepted_q          <= admit;
			dropped_q           <= is_arr && drop_q;
			departure_time_q    <= admit ? dep_time : '0;
			occupancy_q         <= clamp32(occ_q);
			arrival_total_q     <= clamp32(arrivals_nx);
			loss_total_q        <= clamp32(losses_nx);
			departure_total_q   <= clamp32(departures_nx);
			observation_total_q <= clamp32(observations_nx);
			idle_total_q        <= clamp32(idle_obs_nx);
			occupancy_sum_q     <= occ_acc_nx;
		end
	end

	assign evt_ready         = ctrl.evt_ready;
	assign res_valid         = res_valid_q;
	assign accepted          = accepted_q;
	assign dropped           = dropped_q;
	assign departure_time    = departure_time_q;
	assign occupancy         = occupancy_q;
	assign arrival_total     = arrival_total_q;
	assign loss_total        = loss_total_q;
	assign departure_total   = departure_total_q;
	assign observation_total = observation_total_q;
	assign idle_total        = idle_total_q;
	assign occupancy_sum     = occupancy_sum_q;

	// checks
	`FBQ_ASSERT_IMPLY(a_commit_slot_free, ctrl.commit, !res_valid_q || res_ready, "commit over a pending result")
	`FBQ_ASSERT_IMPLY(a_div_start_idle, ctrl.div_start, !div_busy && !evt_ready, "divider restarted while busy")
	`FBQ_ASSERT_IMPLY(a_acc_drop_excl, res_valid_q, !(accepted_q && dropped_q), "arrival both admitted and dropped")
	`FBQ_ASSERT_NEXT(a_dep_zero, ctrl.commit && !admit, departure_time_q == '0, "departure time set on non-admitted request")

endmodule
